// ----- src/modular_add_sub_mul_unit_assert.svh -----
// assertion macros for the modular arithmetic unit
// no dependencies; define NO_ASSERTIONS to drop all checks
`ifndef MODULAR_ADD_SUB_MUL_UNIT_ASSERT_SVH
`define MODULAR_ADD_SUB_MUL_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MAU_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MAU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MAU_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MAU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- src/mau_pkg.sv -----
// shared types and constants for the modular arithmetic unit
// no dependencies
package mau_pkg;
    localparam int WORDS = 4;
    localparam int WORD_BITS = 64;
    localparam int NUM_BITS = WORDS * WORD_BITS;
    localparam int WIDX_BITS = $clog2(WORDS);
    localparam int BIT_IDX_BITS = $clog2(NUM_BITS);
    localparam int CFG_IDX_BITS = 3;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [NUM_BITS-1:0] num_t;

    // one classified job between front and back
    typedef struct packed {
        num_t       a;
        num_t       b;
        logic       is_mul;
        logic       is_sub;
        logic       use_q;
    } job_t;
endpackage

// ----- src/mau_if.sv -----
// valid/ready channel interfaces for the modular arithmetic unit
// depends on mau_pkg
interface mau_in_if import mau_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       modulus_sel;
    word_t      a_word;
    word_t      b_word;
    logic       last_word;
    modport source (output valid, opcode, modulus_sel, a_word, b_word, last_word,
                    input ready);
    modport sink (input valid, opcode, modulus_sel, a_word, b_word, last_word,
                  output ready);
endinterface

interface mau_out_if import mau_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t result_word;
    logic  result_last;
    modport source (output valid, result_word, result_last, input ready);
    modport sink (input valid, result_word, result_last, output ready);
endinterface

// ----- src/modular_add_sub_mul_unit.sv -----
// modular arithmetic unit top level: 256-bit add, sub, mul mod p or q
// from last operand word to first result word: front job register, then two passes
// of 256 bit steps (double, then add when the bit is set), then combine for add/sub
// throughput: one operation at a time, result words one per cycle while ready; the front
// holds one finished job so the next operand words can load meanwhile
// reset: async active low clears word count, control state, modulus registers; operand stores undefined
module modular_add_sub_mul_unit import mau_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    mau_in_if.sink                  in_ch,
    mau_out_if.source               out_ch,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  word_t                   cfg_data
);
    // modulus registers, low word first
    word_t p_word_reg [WORDS];
    word_t q_word_reg [WORDS];
    num_t p_mod;
    num_t q_mod;
    logic job_valid;
    logic job_ready;
    job_t job;

    always_comb
    begin
        for (int i = 0; i < WORDS; i++)
        begin
            p_mod[i*WORD_BITS +: WORD_BITS] = p_word_reg[i];
            q_mod[i*WORD_BITS +: WORD_BITS] = q_word_reg[i];
        end
    end

    // config writes: index 0..3 p, 4..7 q
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORDS; i++)
            begin
                p_word_reg[i] <= '0;
                q_word_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index[2])
                q_word_reg[cfg_index[1:0]] <= cfg_data;
            else
                p_word_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    // front collects words, back computes and streams result
    mau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    mau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .p_mod     (p_mod),
        .q_mod     (q_mod),
        .out_ch    (out_ch)
    );
endmodule

// ----- src/mau_front.sv -----
// front: gathers operand words and classifies the job
// depends on mau_pkg, mau_if
module mau_front import mau_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    mau_in_if.sink        in_ch,
    output logic          job_valid,
    input  logic          job_ready,
    output job_t          job
);
    word_t a_store_reg [WORDS];
    word_t b_store_reg [WORDS];
    logic [WIDX_BITS-1:0] word_count_reg;
    logic [WIDX_BITS-1:0] word_count_next;
    logic job_valid_reg;
    job_t job_reg;
    logic take;
    num_t a_cat;
    num_t b_cat;

    // hold input while a finished job waits for the back
    assign in_ch.ready = !job_valid_reg;
    assign take = in_ch.valid && in_ch.ready;
    assign job_valid = job_valid_reg;
    assign job = job_reg;

    always_comb
    begin
        for (int i = 0; i < WORDS; i++)
        begin
            a_cat[i*WORD_BITS +: WORD_BITS] = a_store_reg[i];
            b_cat[i*WORD_BITS +: WORD_BITS] = b_store_reg[i];
        end
        // last word bypasses the store
        a_cat[word_count_reg*WORD_BITS +: WORD_BITS] = in_ch.a_word;
        b_cat[word_count_reg*WORD_BITS +: WORD_BITS] = in_ch.b_word;
        word_count_next = word_count_reg;
        if (take)
        begin
            word_count_next = in_ch.last_word ? '0 : word_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_store_reg[word_count_reg] <= in_ch.a_word;
            b_store_reg[word_count_reg] <= in_ch.b_word;
        end
        if (take && in_ch.last_word)
        begin
            job_reg.a <= a_cat;
            job_reg.b <= b_cat;
            job_reg.is_mul <= in_ch.opcode[1];
            job_reg.is_sub <= (in_ch.opcode == OP_SUB);
            job_reg.use_q <= in_ch.modulus_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            word_count_reg <= word_count_next;
            if (take && in_ch.last_word)
                job_valid_reg <= 1'b1;
            else if (job_ready)
                job_valid_reg <= 1'b0;
        end
    end
endmodule

// ----- src/mau_back.sv -----
// back: bit-serial modular reduce, add, subtract and multiply, word output
// depends on mau_pkg, mau_if, assertion macros
`include "modular_add_sub_mul_unit_assert.svh"
module mau_back import mau_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  job_t          job,
    input  num_t          p_mod,
    input  num_t          q_mod,
    mau_out_if.source     out_ch
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED_A = 3'd1;
    localparam logic [2:0] S_RED_B = 3'd2;
    localparam logic [2:0] S_MUL = 3'd3;
    localparam logic [2:0] S_COMB = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0] state_reg, state_next;
    job_t job_reg;
    num_t m_reg;
    num_t acc_reg, acc_next;
    num_t ar_reg;
    num_t br_reg;
    logic [BIT_IDX_BITS-1:0] bit_reg;
    logic phase_reg;
    logic [WIDX_BITS-1:0] out_idx_reg;

    // one modular add step: operands below m
    num_t add_x, add_y, add_r;
    logic [NUM_BITS:0] add_s;
    logic [NUM_BITS:0] add_d;
    logic [NUM_BITS:0] sub_d;
    logic cur_bit;
    num_t src;

    always_comb
    begin
        add_s = {1'b0, add_x} + {1'b0, add_y};
        add_d = add_s - {1'b0, m_reg};
        add_r = add_d[NUM_BITS] ? add_s[NUM_BITS-1:0] : add_d[NUM_BITS-1:0];
    end

    always_comb
    begin
        src = (state_reg == S_RED_B) ? job_reg.b :
              (state_reg == S_MUL) ? job_reg.b : job_reg.a;
        cur_bit = src[bit_reg];
        // doubling on phase 0, add on phase 1
        add_x = acc_reg;
        add_y = phase_reg ? ((state_reg == S_MUL) ? ar_reg : {{(NUM_BITS-1){1'b0}}, 1'b1})
                          : acc_reg;
        if (state_reg == S_COMB)
        begin
            add_x = ar_reg;
            add_y = br_reg;
        end
        sub_d = {1'b0, ar_reg} - {1'b0, br_reg};
    end

    assign job_ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.result_word = acc_reg[out_idx_reg*WORD_BITS +: WORD_BITS];
    assign out_ch.result_last = (out_idx_reg == WIDX_BITS'(WORDS-1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (job_valid) state_next = S_RED_A;
            S_RED_A, S_RED_B, S_MUL:
                if (bit_reg == '0 && (phase_reg || !cur_bit))
                begin
                    if (state_reg == S_RED_A)
                        state_next = job_reg.is_mul ? S_MUL : S_RED_B;
                    else if (state_reg == S_RED_B)
                        state_next = S_COMB;
                    else
                        state_next = S_OUT;
                end
            S_COMB:
                state_next = S_OUT;
            S_OUT:
                if (out_ch.ready && out_ch.result_last) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (state_reg == S_COMB)
        begin
            if (job_reg.is_sub)
                acc_next = sub_d[NUM_BITS] ? sub_d[NUM_BITS-1:0] + m_reg
                                           : sub_d[NUM_BITS-1:0];
            else
                acc_next = add_r;
        end
        else if (state_reg == S_RED_A || state_reg == S_RED_B || state_reg == S_MUL)
            acc_next = add_r;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg <= job;
                m_reg <= job.use_q ? q_mod : p_mod;
                acc_reg <= '0;
                bit_reg <= BIT_IDX_BITS'(NUM_BITS-1);
                phase_reg <= 1'b0;
                out_idx_reg <= '0;
            end
            S_RED_A, S_RED_B, S_MUL:
            begin
                if (!phase_reg && cur_bit)
                begin
                    acc_reg <= acc_next;
                    phase_reg <= 1'b1;
                end
                else if (bit_reg != '0)
                begin
                    acc_reg <= acc_next;
                    phase_reg <= 1'b0;
                    bit_reg <= bit_reg - 1'b1;
                end
                else
                begin
                    // end of a reduction or multiply pass
                    phase_reg <= 1'b0;
                    bit_reg <= BIT_IDX_BITS'(NUM_BITS-1);
                    if (state_reg == S_RED_A)
                    begin
                        ar_reg <= acc_next;
                        acc_reg <= '0;
                    end
                    else if (state_reg == S_RED_B)
                    begin
                        br_reg <= acc_next;
                        acc_reg <= '0;
                    end
                    else
                        acc_reg <= (m_reg == '0) ? '0 : acc_next;
                end
            end
            S_COMB:
                acc_reg <= (m_reg == '0) ? '0 : acc_next;
            S_OUT:
                if (out_ch.ready) out_idx_reg <= out_idx_reg + 1'b1;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `MAU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.result_word), "result word changed while waiting")
    `MAU_ASSERT_NEXT(a_last_to_idle, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.result_last, state_reg == S_IDLE, "no idle after last word")
    `MAU_ASSERT_NEXT(a_job_leaves_idle, clk, rst_n, job_valid && job_ready, state_reg == S_RED_A, "job not started")
endmodule

// ----- tb/mau_checker.sv -----
// result checker for the modular arithmetic unit: watches both channels and
// the register write port, predicts each result word and compares
// depends on mau_pkg and mau_if
module mau_checker import mau_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    mau_in_if                       in_ch,
    mau_out_if                      out_ch,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  word_t                   cfg_data,
    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        word_t data;
        logic  last;
    } result_word_t;

    word_t         p_mod [WORDS];
    word_t         q_mod [WORDS];
    word_t         a_held [WORDS];
    word_t         b_held [WORDS];
    int            pos;
    result_word_t  expected_words [$];

    assign pending = expected_words.size();

    // residue arithmetic on whole numbers
    function automatic num_t modular_result(logic [1:0] op, num_t a, num_t b, num_t m);
        logic [2*NUM_BITS-1:0] wide;
        num_t ar;
        num_t br;
        if (m == '0)
            return '0;
        ar = a % m;
        br = b % m;
        if (op[1])
        begin
            wide = {{NUM_BITS{1'b0}}, ar} * {{NUM_BITS{1'b0}}, br};
            wide = wide % {{NUM_BITS{1'b0}}, m};
            return wide[NUM_BITS-1:0];
        end
        wide = (op == OP_ADD) ? {{NUM_BITS{1'b0}}, ar} + br
                              : {{NUM_BITS{1'b0}}, ar} + m - br;
        wide = wide % {{NUM_BITS{1'b0}}, m};
        return wide[NUM_BITS-1:0];
    endfunction

    task automatic report(string what, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        num_t a;
        num_t b;
        num_t m;
        num_t r;
        result_word_t w;
        if (!rst_n)
        begin
            for (int i = 0; i < WORDS; i++)
            begin
                p_mod[i] = '0;
                q_mod[i] = '0;
                a_held[i] = '0;
                b_held[i] = '0;
            end
            pos = 0;
            fail_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index < WORDS)
                    p_mod[cfg_index] = cfg_data;
                else
                    q_mod[cfg_index - WORDS] = cfg_data;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                a_held[pos] = in_ch.a_word;
                b_held[pos] = in_ch.b_word;
                if (!in_ch.last_word)
                    pos = (pos + 1) % WORDS;
                else
                begin
                    pos = 0;
                    for (int i = 0; i < WORDS; i++)
                    begin
                        a[i*WORD_BITS +: WORD_BITS] = a_held[i];
                        b[i*WORD_BITS +: WORD_BITS] = b_held[i];
                        m[i*WORD_BITS +: WORD_BITS] = in_ch.modulus_sel ? q_mod[i] : p_mod[i];
                    end
                    r = modular_result(in_ch.opcode, a, b, m);
                    for (int i = 0; i < WORDS; i++)
                    begin
                        w.data = r[i*WORD_BITS +: WORD_BITS];
                        w.last = (i == WORDS - 1);
                        expected_words.push_back(w);
                    end
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                    report("unexpected result word", '0, out_ch.result_word);
                else
                begin
                    w = expected_words.pop_front();
                    if (out_ch.result_word !== w.data)
                        report("result_word", w.data, out_ch.result_word);
                    if (out_ch.result_last !== w.last)
                        report("result_last", 64'(w.last), 64'(out_ch.result_last));
                end
            end
        end
    end
endmodule

// ----- tb/tb_modular_add_sub_mul_unit.sv -----
// top of the modular arithmetic unit testbench: clock, reset, register writes,
// operand stimulus and verdict; depends on mau_pkg, mau_if, mau_checker, the DUT
module tb_modular_add_sub_mul_unit;
    import mau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // bit 1 alone selects multiply, so opcode three multiplies too
    localparam logic [1:0] OP_MUL_ALIAS = OP_MUL | OP_SUB;
    localparam int CYCLE_LIMIT = 1500000;
    localparam num_t K1_PRIME =
        256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFD97;
    localparam num_t K1_ORDER =
        256'h400000000000000000000000000000000FD8CDDFC87B6635C115AF556C360C67;
    localparam num_t SMALL_MOD = 256'h269;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    word_t                   cfg_data = '0;
    int                      fail_count;
    int                      pending;
    int                      cycles = 0;
    int                      items_sent = 0;
    int                      send_gap_pct = 0;
    int                      recv_stall_pct = 0;
    num_t                    cur_p;
    num_t                    cur_q;

    mau_in_if  in_ch ();
    mau_out_if out_ch ();

    modular_add_sub_mul_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mau_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver side: random back-pressure at the configured rate
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic num_t rand_num();
        num_t v;
        for (int i = 0; i < NUM_BITS / 32; i++)
            v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    // operand mostly below the modulus, sometimes any value at all
    function automatic num_t rand_operand(num_t m);
        num_t v;
        v = rand_num();
        if (m != '0 && $urandom_range(7) != 0)
            v = v % m;
        return v;
    endfunction

    // write both moduli, all eight registers, only while the block is idle
    task automatic write_moduli(num_t p, num_t q);
        cur_p = p;
        cur_q = q;
        for (int i = 0; i < 2 * WORDS; i++)
        begin
            @(negedge clk);
            cfg_we = 1'b1;
            cfg_index = i[CFG_IDX_BITS-1:0];
            cfg_data = (i < WORDS) ? p[i*WORD_BITS +: WORD_BITS]
                                   : q[(i-WORDS)*WORD_BITS +: WORD_BITS];
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // wait until every expected word is back, then let the back end settle
    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    // one word per handshake; nwords other than WORDS gives early or overlong
    // sequences, word index wraps like the block's position counter
    task automatic send_op(logic [1:0] op, logic sel, num_t a, num_t b, int nwords);
        bit taken;
        int k;
        for (int i = 0; i < nwords; i++)
        begin
            if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
            begin
                in_ch.valid = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            k = i % WORDS;
            in_ch.valid = 1'b1;
            in_ch.opcode = op;
            in_ch.modulus_sel = sel;
            in_ch.a_word = a[k*WORD_BITS +: WORD_BITS];
            in_ch.b_word = b[k*WORD_BITS +: WORD_BITS];
            in_ch.last_word = (i == nwords - 1);
            taken = 1'b0;
            while (!taken)
            begin
                @(posedge clk);
                taken = in_ch.ready;
                @(negedge clk);
            end
            items_sent++;
        end
        in_ch.valid = 1'b0;
    endtask

    task automatic random_op();
        logic sel;
        num_t m;
        int n;
        sel = $urandom_range(1);
        m = sel ? cur_q : cur_p;
        // mostly clean four-word operations, the rest short or overlong
        if ($urandom_range(99) < 85)
            n = WORDS;
        else if ($urandom_range(1))
            n = $urandom_range(1, WORDS - 1);
        else
            n = $urandom_range(WORDS + 1, 2 * WORDS - 1);
        send_op($urandom_range(3), sel, rand_operand(m), rand_operand(m), n);
    endtask

    initial
    begin
        num_t all_ones;
        int target;
        all_ones = '1;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_ADD;
        in_ch.modulus_sel = 1'b0;
        in_ch.a_word = '0;
        in_ch.b_word = '0;
        in_ch.last_word = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed: curve prime and order, edge operands, every operation
        write_moduli(K1_PRIME, K1_ORDER);
        send_op(OP_ADD, 1'b0, '0, '0, WORDS);
        send_op(OP_SUB, 1'b1, '0, 256'h1, WORDS);            // a below b wraps
        send_op(OP_MUL_ALIAS, 1'b0, all_ones, all_ones, WORDS); // operands above p
        send_op(OP_ADD, 1'b0, K1_PRIME - 1, K1_PRIME - 1, WORDS);
        send_op(OP_MUL, 1'b1, K1_ORDER - 1, K1_ORDER - 1, WORDS);
        send_op(OP_ADD, 1'b1, rand_num(), rand_num(), 2);       // early last word
        drain();
        send_op(OP_SUB, 1'b0, all_ones, '0, WORDS + 2);          // too many words
        drain();

        // random phases: each pairs a modulus setting with an idling mode
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0: write_moduli(K1_PRIME, K1_ORDER);
                1: write_moduli(all_ones, 256'h1);                  // largest and smallest
                2: write_moduli(SMALL_MOD, '0);                     // zero modulus q
                default: write_moduli(rand_num(), rand_num() >> $urandom_range(255));
            endcase
            case (phase)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
                default: begin send_gap_pct = 16; recv_stall_pct = 16; end
            endcase
            target = items_sent + 115;
            while (items_sent < target)
                random_op();
        end

        // end of stimulus: wait for the last results plus some slack
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
